FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the positioner RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define BTPC_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never hold
`define BTPC_ASSERT_NEVER(label, cond, msg) \
    `BTPC_ASSERT_CLK(label, !(cond), msg)

`endif

FILE: rtl/core/btpc_pkg.sv
// ---------------------------------------------------------------------------
// btpc_pkg
// Types, codes and constants of the blind tilt positioner.
// ---------------------------------------------------------------------------
package btpc_pkg;

    localparam int REPORT_INTERVAL_MS = 1000;
    localparam int MS_PER_S           = 1000;

    localparam int OP_W        = 3;
    localparam int POS_W       = 12;
    localparam int TGT_W       = 10;
    localparam int TARGET_W    = 11;
    localparam int IDLE_W      = 22;
    localparam int REPORT_W    = 10;
    localparam int TIMEOUT_W   = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int STEP_W      = 2;
    localparam int CMP_W       = 14;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK         = 3'd0;
    localparam logic [OP_W-1:0] OP_STOP         = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_POSITION = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_TILT     = 3'd3;
    localparam logic [OP_W-1:0] OP_FAULT_RESET  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOISY         = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE        = 2'd2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 12'd10;

    // step positions
    localparam logic [STEP_W-1:0] STEP_CLOSED = 2'd0;
    localparam logic [STEP_W-1:0] STEP_HALF   = 2'd1;
    localparam logic [STEP_W-1:0] STEP_OPEN   = 2'd2;

    localparam int POS_CLOSED     = 0;
    localparam int POS_HALF       = 500;
    localparam int POS_OPEN       = 1000;
    localparam int BAND_FINE      = 5;
    localparam int BAND_WIDE      = 50;
    localparam int SETTLE_DELTA   = 5;
    localparam int END_LOW        = 5;
    localparam int END_HIGH       = 995;
    localparam int STEP_LOW_EDGE  = 250;
    localparam int STEP_HIGH_EDGE = 750;
    localparam int SNAP_WIN       = 50;

    localparam logic [IDLE_W-1:0]   IDLE_MAX   = '1;
    localparam logic [REPORT_W-1:0] REPORT_MAX = '1;
    localparam logic [REPORT_W-1:0] REPORT_DUE = REPORT_W'(REPORT_INTERVAL_MS);

    typedef enum logic [1:0] {
        DRIVE_STOP  = 2'd0,
        DRIVE_OPEN  = 2'd1,
        DRIVE_CLOSE = 2'd2
    } drive_t;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [POS_W-1:0] angle_sample;
        logic                    sample_valid;
        logic [TGT_W-1:0]        target_tenths;
    } btpc_item_t;

    typedef struct packed {
        drive_t                  motor_drive;
        logic signed [POS_W-1:0] reported_percent;
        logic                    fault_active;
        logic                    target_reached;
        logic                    position_report;
        logic                    command_rejected;
    } btpc_result_t;

    typedef struct packed {
        logic [IDLE_W-1:0] stall_limit_ms;
        logic              noisy;
        logic              source_ok;
    } btpc_cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] current_position;
        logic signed [POS_W-1:0] last_seen_position;
        logic                    last_seen_known;
        logic [TARGET_W-1:0]     target_position;
        logic                    target_active;
        logic [IDLE_W-1:0]       idle_ms;
        logic [REPORT_W-1:0]     report_ms;
        drive_t                  drive_state;
        logic [STEP_W-1:0]       step_index;
        logic                    fault_flag;
    } btpc_state_t;

    localparam btpc_state_t STATE_RESET = '{
        current_position:   '0,
        last_seen_position: '0,
        last_seen_known:    1'b0,
        target_position:    '0,
        target_active:      1'b0,
        idle_ms:            '0,
        report_ms:          '0,
        drive_state:        DRIVE_STOP,
        step_index:         STEP_CLOSED,
        fault_flag:         1'b0
    };

    function automatic logic [STEP_W-1:0] step_of(input logic [TGT_W-1:0] t);
        logic [STEP_W-1:0] s;
        begin
            if (t < TGT_W'(STEP_LOW_EDGE))
            begin
                s = STEP_CLOSED;
            end
            else if (t < TGT_W'(STEP_HIGH_EDGE))
            begin
                s = STEP_HALF;
            end
            else
            begin
                s = STEP_OPEN;
            end
            return s;
        end
    endfunction

    function automatic logic [TARGET_W-1:0] step_target(input logic [STEP_W-1:0] s);
        logic [TARGET_W-1:0] t;
        begin
            if (s == STEP_CLOSED)
            begin
                t = TARGET_W'(POS_CLOSED);
            end
            else if (s == STEP_HALF)
            begin
                t = TARGET_W'(POS_HALF);
            end
            else
            begin
                t = TARGET_W'(POS_OPEN);
            end
            return t;
        end
    endfunction

endpackage

FILE: rtl/core/btpc_in_if.sv
// ---------------------------------------------------------------------------
// btpc_in_if
// Input channel: valid/ready handshake with one item word.
// ---------------------------------------------------------------------------
interface btpc_in_if import btpc_pkg::*;;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [POS_W-1:0] angle_sample;
    logic                    sample_valid;
    logic [TGT_W-1:0]        target_tenths;

    modport source (
        output valid, operation, angle_sample, sample_valid, target_tenths,
        input  ready
    );

    modport sink (
        input  valid, operation, angle_sample, sample_valid, target_tenths,
        output ready
    );

endinterface

FILE: rtl/core/btpc_out_if.sv
// ---------------------------------------------------------------------------
// btpc_out_if
// Result channel: valid/ready handshake with one status word.
// ---------------------------------------------------------------------------
interface btpc_out_if import btpc_pkg::*;;

    logic                    valid;
    logic                    ready;
    logic [1:0]              motor_drive;
    logic signed [POS_W-1:0] reported_percent;
    logic                    fault_active;
    logic                    target_reached;
    logic                    position_report;
    logic                    command_rejected;

    modport source (
        output valid, motor_drive, reported_percent, fault_active, target_reached,
               position_report, command_rejected,
        input  ready
    );

    modport sink (
        input  valid, motor_drive, reported_percent, fault_active, target_reached,
               position_report, command_rejected,
        output ready
    );

endinterface

FILE: rtl/core/btpc_cfg_regs.sv
// ---------------------------------------------------------------------------
// btpc_cfg_regs
// Configuration registers and the derived stall limit in milliseconds.
// ---------------------------------------------------------------------------
module btpc_cfg_regs import btpc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output btpc_cfg_t              cfg
);

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 noisy_reg;
    logic                 source_reg;
    logic [TIMEOUT_W-1:0] timeout_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            noisy_reg   <= 1'b0;
            source_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FAULT_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                CFG_NOISY:         noisy_reg   <= cfg_data[0];
                CFG_SOURCE:        source_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // a zero timeout behaves as one second
    assign timeout_eff = (timeout_reg == '0) ? TIMEOUT_W'(1) : timeout_reg;

    assign cfg.stall_limit_ms = IDLE_W'(timeout_eff) * IDLE_W'(MS_PER_S);
    assign cfg.noisy          = noisy_reg;
    assign cfg.source_ok      = source_reg;

endmodule

FILE: rtl/core/btpc_step.sv
// ---------------------------------------------------------------------------
// btpc_step
// Next-state and result logic for one item of the positioner.
// ---------------------------------------------------------------------------
module btpc_step import btpc_pkg::*; (
    input  btpc_item_t   item,
    input  btpc_cfg_t    cfg,
    input  btpc_state_t  state_cur,
    output btpc_state_t  state_next,
    output btpc_result_t result
);

    localparam logic signed [CMP_W-1:0] SETTLE   = CMP_W'(SETTLE_DELTA);
    localparam logic signed [CMP_W-1:0] B_FINE   = CMP_W'(BAND_FINE);
    localparam logic signed [CMP_W-1:0] B_WIDE   = CMP_W'(BAND_WIDE);
    localparam logic signed [CMP_W-1:0] SNAP     = CMP_W'(SNAP_WIN);
    localparam logic signed [CMP_W-1:0] P_CLOSED = CMP_W'(POS_CLOSED);
    localparam logic signed [CMP_W-1:0] P_HALF   = CMP_W'(POS_HALF);
    localparam logic signed [CMP_W-1:0] P_OPEN   = CMP_W'(POS_OPEN);

    logic signed [CMP_W-1:0] band_w;
    logic signed [CMP_W-1:0] sample_w;
    logic signed [CMP_W-1:0] last_w;
    logic signed [CMP_W-1:0] diff_w;
    logic                    sample_used;
    logic                    sample_moved;
    logic signed [POS_W-1:0] pos_tick;
    logic signed [CMP_W-1:0] pos_tick_w;
    logic signed [CMP_W-1:0] tgt_keep_w;
    logic                    hit;

    logic                    is_tilt;
    logic                    end_low;
    logic                    end_high;
    logic [STEP_W-1:0]       step_dn;
    logic [STEP_W-1:0]       step_up;
    logic [STEP_W-1:0]       cmd_step;
    logic [TARGET_W-1:0]     cmd_target;
    logic signed [CMP_W-1:0] cmd_target_w;
    logic signed [CMP_W-1:0] cur_w;
    drive_t                  cmd_drive;

    logic signed [POS_W-1:0] pos_final;
    logic signed [CMP_W-1:0] pos_final_w;
    logic signed [POS_W-1:0] pct_snap;

    btpc_state_t s;
    logic        reached;
    logic        report;
    logic        rejected;

    assign band_w   = cfg.noisy ? B_WIDE : B_FINE;
    assign sample_w = CMP_W'(item.angle_sample);
    assign last_w   = CMP_W'(state_cur.last_seen_position);
    assign cur_w    = CMP_W'(state_cur.current_position);
    assign diff_w   = sample_w - last_w;

    // tick: sample handling
    assign sample_used  = cfg.source_ok && item.sample_valid;
    assign sample_moved = !state_cur.last_seen_known || diff_w > SETTLE || diff_w < -SETTLE;
    assign pos_tick     = sample_used ? item.angle_sample : state_cur.current_position;
    assign pos_tick_w   = CMP_W'(pos_tick);
    assign tgt_keep_w   = CMP_W'({1'b0, state_cur.target_position});

    assign hit = (state_cur.drive_state == DRIVE_OPEN  && pos_tick_w >= tgt_keep_w - band_w) ||
                 (state_cur.drive_state == DRIVE_CLOSE && pos_tick_w <= tgt_keep_w + band_w);

    // commands: target and step selection
    assign is_tilt  = (item.operation == OP_SET_TILT);
    assign end_low  = (item.target_tenths <= TGT_W'(END_LOW));
    assign end_high = (item.target_tenths >= TGT_W'(END_HIGH));
    assign step_dn  = (state_cur.step_index != STEP_CLOSED) ?
                      state_cur.step_index - 1'b1 : STEP_CLOSED;
    assign step_up  = (state_cur.step_index < STEP_OPEN) ?
                      state_cur.step_index + 1'b1 : STEP_OPEN;

    always_comb
    begin
        if (is_tilt)
        begin
            cmd_step   = step_of(item.target_tenths);
            cmd_target = TARGET_W'(item.target_tenths);
        end
        else if (end_low)
        begin
            cmd_step   = step_dn;
            cmd_target = step_target(step_dn);
        end
        else if (end_high)
        begin
            cmd_step   = step_up;
            cmd_target = step_target(step_up);
        end
        else
        begin
            cmd_step   = step_of(item.target_tenths);
            cmd_target = TARGET_W'(item.target_tenths);
        end
    end

    assign cmd_target_w = CMP_W'({1'b0, cmd_target});

    always_comb
    begin
        if (cmd_target_w > cur_w + band_w)
        begin
            cmd_drive = DRIVE_OPEN;
        end
        else if (cmd_target_w < cur_w - band_w)
        begin
            cmd_drive = DRIVE_CLOSE;
        end
        else
        begin
            cmd_drive = DRIVE_STOP;
        end
    end

    always_comb
    begin
        s        = state_cur;
        reached  = 1'b0;
        report   = 1'b0;
        rejected = 1'b0;
        unique case (item.operation)
            OP_TICK:
            begin
                if (state_cur.idle_ms != IDLE_MAX)
                begin
                    s.idle_ms = state_cur.idle_ms + 1'b1;
                end
                if (state_cur.report_ms != REPORT_MAX)
                begin
                    s.report_ms = state_cur.report_ms + 1'b1;
                end
                if (sample_used && sample_moved)
                begin
                    s.idle_ms            = '0;
                    s.last_seen_position = item.angle_sample;
                    s.last_seen_known    = 1'b1;
                end
                s.current_position = pos_tick;
                if (state_cur.drive_state != DRIVE_STOP)
                begin
                    if (s.idle_ms > cfg.stall_limit_ms && !state_cur.fault_flag)
                    begin
                        s.fault_flag    = 1'b1;
                        s.drive_state   = DRIVE_STOP;
                        s.target_active = 1'b0;
                    end
                    else if (!state_cur.fault_flag && state_cur.target_active)
                    begin
                        if (hit)
                        begin
                            s.drive_state   = DRIVE_STOP;
                            s.target_active = 1'b0;
                            reached         = 1'b1;
                        end
                        else if (s.report_ms >= REPORT_DUE)
                        begin
                            s.report_ms = '0;
                            report      = 1'b1;
                        end
                    end
                end
            end
            OP_STOP, OP_SET_POSITION, OP_SET_TILT:
            begin
                if (!cfg.source_ok || state_cur.fault_flag)
                begin
                    rejected = 1'b1;
                end
                else if (item.operation == OP_STOP)
                begin
                    s.drive_state   = DRIVE_STOP;
                    s.target_active = 1'b0;
                end
                else
                begin
                    s.step_index      = cmd_step;
                    s.target_position = cmd_target;
                    s.target_active   = 1'b1;
                    s.idle_ms         = '0;
                    s.last_seen_known = 1'b0;
                    s.drive_state     = cmd_drive;
                end
            end
            OP_FAULT_RESET:
            begin
                if (state_cur.fault_flag)
                begin
                    s.fault_flag      = 1'b0;
                    s.idle_ms         = '0;
                    s.last_seen_known = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // report snapping on a noisy source
    assign pos_final   = (item.operation == OP_TICK) ? pos_tick : state_cur.current_position;
    assign pos_final_w = CMP_W'(pos_final);

    always_comb
    begin
        pct_snap = pos_final;
        if (cfg.noisy)
        begin
            if (pos_final_w >= P_HALF - SNAP && pos_final_w <= P_HALF + SNAP)
            begin
                pct_snap = POS_W'(POS_HALF);
            end
            else if (pos_final_w <= P_CLOSED && pos_final_w >= P_CLOSED - SNAP)
            begin
                pct_snap = POS_W'(POS_CLOSED);
            end
            else if (pos_final_w >= P_OPEN && pos_final_w <= P_OPEN + SNAP)
            begin
                pct_snap = POS_W'(POS_OPEN);
            end
        end
    end

    assign result.reported_percent = pct_snap;
    assign result.motor_drive      = s.drive_state;
    assign result.fault_active     = s.fault_flag;
    assign result.target_reached   = reached;
    assign result.position_report  = report;
    assign result.command_rejected = rejected;
    assign state_next              = s;

endmodule

FILE: rtl/core/blind_tilt_position_controller.sv
// ---------------------------------------------------------------------------
// blind_tilt_position_controller
// Bang-bang tilt positioner for a motorized blind, one status word per item.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake         | word
//  in_ch    | in  | valid/ready       | operation, angle_sample, sample_valid,
//           |     |                   | target_tenths
//  out_ch   | out | valid/ready       | motor_drive, reported_percent, flags
//  cfg_*    | in  | cfg_write strobe  | cfg_index, cfg_data
//
//  One word per cycle sustained while out_ch is not stalled; the status word
//  is offered once its input word has passed the input register, then the
//  update logic into the state and result registers.
//  Reset clears handshake control and positioner state; configuration comes
//  back to its default values. A stalled result holds while a new word is
//  still taken into an empty input register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module blind_tilt_position_controller import btpc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    btpc_in_if.sink                in_ch,
    btpc_out_if.source             out_ch,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    btpc_cfg_t    cfg;
    btpc_item_t   item_reg;
    logic         in_valid_reg;
    btpc_state_t  state_reg;
    btpc_state_t  state_next;
    btpc_result_t result_next;
    btpc_result_t result_reg;
    logic         out_valid_reg;
    logic         advance;
    logic         fault_drive;
    logic         both_pulses;

    btpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    btpc_step u_step (
        .item       (item_reg),
        .cfg        (cfg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_reg.operation     <= in_ch.operation;
            item_reg.angle_sample  <= in_ch.angle_sample;
            item_reg.sample_valid  <= in_ch.sample_valid;
            item_reg.target_tenths <= in_ch.target_tenths;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.motor_drive      = result_reg.motor_drive;
    assign out_ch.reported_percent = result_reg.reported_percent;
    assign out_ch.fault_active     = result_reg.fault_active;
    assign out_ch.target_reached   = result_reg.target_reached;
    assign out_ch.position_report  = result_reg.position_report;
    assign out_ch.command_rejected = result_reg.command_rejected;

    assign fault_drive = result_reg.fault_active && (result_reg.motor_drive != DRIVE_STOP);
    assign both_pulses = result_reg.target_reached && result_reg.position_report;

    // a latched fault always leaves the motor stopped
    `BTPC_ASSERT_NEVER(a_fault_stops, out_valid_reg && fault_drive, "motor running with fault")
    // arrival and periodic report never pulse together
    `BTPC_ASSERT_NEVER(a_pulse_excl, out_valid_reg && both_pulses, "arrival and report together")
    // step index stays within closed/half/open
    `BTPC_ASSERT_NEVER(a_step_range, state_reg.step_index > STEP_OPEN, "step index out of range")
    // an advancing word always lands in the result register
    `BTPC_ASSERT_CLK(a_adv_out, advance |=> out_valid_reg, "result lost after advance")

endmodule
